@@ sv/bme_pkg.sv @@
// ---------------------------------------------------------------------------
// Bytewise modular exponentiation package
// Widths, register addresses, reset values and the microcode program that
// drives the exponentiation datapath.
// ---------------------------------------------------------------------------
package bme_pkg;

   localparam int MODULUS_BITS   = 16;
   localparam int EXPONENT_BITS  = 8;
   localparam int SYMBOL_BITS    = 8;
   localparam int REQ_TDATA_BITS = ((SYMBOL_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((MODULUS_BITS + 7) / 8) * 8;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int EXP_IDX_BITS   = $clog2(EXPONENT_BITS);
   localparam int MUL_CNT_BITS   = $clog2(MODULUS_BITS);
   localparam int STEP_BITS      = 3;

   localparam logic [EXPONENT_BITS-1:0] EXPONENT_RESET = EXPONENT_BITS'(5);
   localparam logic [MODULUS_BITS-1:0]  MODULUS_RESET  = MODULUS_BITS'(65535);

   // Register indexes, taken from the word address.
   localparam logic REG_EXPONENT = 1'b0;
   localparam logic REG_MODULUS  = 1'b1;

   // Multiplier operand and destination selects.
   localparam logic OPA_ONE  = 1'b0;
   localparam logic OPA_ACC  = 1'b1;
   localparam logic OPB_BASE = 1'b0;
   localparam logic OPB_ACC  = 1'b1;
   localparam logic DST_BASE = 1'b0;
   localparam logic DST_ACC  = 1'b1;

   // Sequencing conditions.
   localparam logic [2:0] COND_NEXT    = 3'd0;
   localparam logic [2:0] COND_REQ     = 3'd1;
   localparam logic [2:0] COND_BIT_CLR = 3'd2;
   localparam logic [2:0] COND_MORE    = 3'd3;
   localparam logic [2:0] COND_EMIT    = 3'd4;

   // Program steps.
   localparam logic [STEP_BITS-1:0] S_WAIT   = 3'd0;
   localparam logic [STEP_BITS-1:0] S_REDUCE = 3'd1;
   localparam logic [STEP_BITS-1:0] S_SQUARE = 3'd2;
   localparam logic [STEP_BITS-1:0] S_TEST   = 3'd3;
   localparam logic [STEP_BITS-1:0] S_MULT   = 3'd4;
   localparam logic [STEP_BITS-1:0] S_LOOP   = 3'd5;
   localparam logic [STEP_BITS-1:0] S_EMIT   = 3'd6;

   typedef struct packed {
      logic                 mul;
      logic                 opa;
      logic                 opb;
      logic                 dst;
      logic [2:0]           cond;
      logic [STEP_BITS-1:0] target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [STEP_BITS-1:0] step);
      ucode_type word;
      word = '{mul: 1'b0, opa: OPA_ONE, opb: OPB_BASE, dst: DST_BASE,
               cond: COND_NEXT, target: S_WAIT};
      unique case (step)
         S_WAIT:   word = '{1'b0, OPA_ONE, OPB_BASE, DST_BASE, COND_REQ,     S_REDUCE};
         S_REDUCE: word = '{1'b1, OPA_ONE, OPB_BASE, DST_BASE, COND_NEXT,    S_SQUARE};
         S_SQUARE: word = '{1'b1, OPA_ACC, OPB_ACC,  DST_ACC,  COND_NEXT,    S_TEST};
         S_TEST:   word = '{1'b0, OPA_ONE, OPB_BASE, DST_BASE, COND_BIT_CLR, S_LOOP};
         S_MULT:   word = '{1'b1, OPA_ACC, OPB_BASE, DST_ACC,  COND_NEXT,    S_LOOP};
         S_LOOP:   word = '{1'b0, OPA_ONE, OPB_BASE, DST_BASE, COND_MORE,    S_SQUARE};
         S_EMIT:   word = '{1'b0, OPA_ONE, OPB_BASE, DST_BASE, COND_EMIT,    S_WAIT};
         default:  word = '{1'b0, OPA_ONE, OPB_BASE, DST_BASE, COND_NEXT,    S_WAIT};
      endcase
      return word;
   endfunction

endpackage

@@ sv/bme_modmul.sv @@
// ---------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes a * b mod n one bit of b per cycle, most significant bit first,
// keeping the partial result below n with a three-way compare and subtract.
// ---------------------------------------------------------------------------
module bme_modmul (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [bme_pkg::MODULUS_BITS-1:0] opa,
   input  logic [bme_pkg::MODULUS_BITS-1:0] opb,
   input  logic [bme_pkg::MODULUS_BITS-1:0] modulus,
   output logic                             done,
   output logic [bme_pkg::MODULUS_BITS-1:0] product
);
   import bme_pkg::*;

   localparam int SUM_BITS = MODULUS_BITS + 2;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [MUL_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [MODULUS_BITS-1:0]   r_ff, r_in;
   logic [MODULUS_BITS-1:0]   a_ff, a_in;
   logic [MODULUS_BITS-1:0]   b_ff, b_in;
   logic [MODULUS_BITS-1:0]   n_ff, n_in;
   logic [SUM_BITS-1:0]       sum;
   logic [SUM_BITS-1:0]       n1;
   logic [SUM_BITS-1:0]       n2;
   logic [SUM_BITS-1:0]       reduced;

   always_comb begin
      n1  = SUM_BITS'(n_ff);
      n2  = SUM_BITS'({n_ff, 1'b0});
      sum = SUM_BITS'({r_ff, 1'b0})
          + (b_ff[MODULUS_BITS-1] ? SUM_BITS'(a_ff) : '0);
      if (sum >= n2) begin
         reduced = sum - n2;
      end else if (sum >= n1) begin
         reduced = sum - n1;
      end else begin
         reduced = sum;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      n_in    = n_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         r_in    = '0;
         a_in    = opa;
         b_in    = opb;
         n_in    = modulus;
      end else if (busy_ff) begin
         r_in   = reduced[MODULUS_BITS-1:0];
         b_in   = {b_ff[MODULUS_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + MUL_CNT_BITS'(1);
         if (cnt_ff == MUL_CNT_BITS'(MODULUS_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      n_ff   <= n_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

endmodule

@@ sv/bytewise_modular_exponentiation.sv @@
// ---------------------------------------------------------------------------
// Bytewise modular exponentiation
// Raises each input byte to the configured exponent modulo the configured
// modulus, using a microcoded square-and-multiply sequencer.
// ---------------------------------------------------------------------------
// Each byte transferred on the request stream yields one residue, symbol to
// the power exponent, reduced modulo modulus, on the response stream. The
// work is done one item at a time by a small microcode program that runs a
// bit-serial modular multiplier: the byte is first reduced with one multiply,
// and every exponent bit costs a square plus one more multiply when the bit
// is set, along with two control steps. The next byte is taken while a
// finished residue still waits on the output. A modulus of zero or one gives
// a residue of zero.
module bytewise_modular_exponentiation (
   input  logic                               clock,
   input  logic                               reset,
   // tdata: symbol [7:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bme_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // tdata: residue [15:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bme_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bme_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [bme_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bme_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import bme_pkg::*;

   logic [EXPONENT_BITS-1:0]  exponent_ff, exponent_in;
   logic [MODULUS_BITS-1:0]   modulus_ff, modulus_in;
   logic [STEP_BITS-1:0]      pc_ff, pc_in;
   logic                      issued_ff, issued_in;
   logic [EXP_IDX_BITS-1:0]   bit_ff, bit_in;
   logic [MODULUS_BITS-1:0]   acc_ff, acc_in;
   logic [MODULUS_BITS-1:0]   base_ff, base_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [MODULUS_BITS-1:0]   rsp_data_ff, rsp_data_in;
   ucode_type                 uc;
   logic                      csr_write;
   logic                      req_xfer;
   logic                      out_free;
   logic                      mul_start;
   logic                      mul_done;
   logic [MODULUS_BITS-1:0]   mul_a;
   logic [MODULUS_BITS-1:0]   mul_b;
   logic [MODULUS_BITS-1:0]   mul_p;
   logic                      modulus_small;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      exponent_in = exponent_ff;
      modulus_in  = modulus_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_EXPONENT: exponent_in = csr_pwdata[EXPONENT_BITS-1:0];
            REG_MODULUS:  modulus_in  = csr_pwdata[MODULUS_BITS-1:0];
            default:      exponent_in = exponent_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_EXPONENT: csr_prdata = CSR_DATA_BITS'(exponent_ff);
         REG_MODULUS:  csr_prdata = CSR_DATA_BITS'(modulus_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // Sequencer.
   assign uc            = ucode_rom(pc_ff);
   assign req_tready    = (pc_ff == S_WAIT);
   assign req_xfer      = req_tvalid & req_tready;
   assign out_free      = ~rsp_valid_ff | rsp_tready;
   assign modulus_small = (modulus_ff[MODULUS_BITS-1:1] == '0);
   assign mul_a         = (uc.opa == OPA_ACC) ? acc_ff : MODULUS_BITS'(1);
   assign mul_b         = (uc.opb == OPB_ACC) ? acc_ff : base_ff;

   always_comb begin
      pc_in        = pc_ff;
      issued_in    = issued_ff;
      bit_in       = bit_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      mul_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (uc.cond)
         COND_REQ: begin
            if (req_xfer) begin
               base_in = MODULUS_BITS'(req_tdata[SYMBOL_BITS-1:0]);
               acc_in  = MODULUS_BITS'(1);
               bit_in  = EXP_IDX_BITS'(EXPONENT_BITS - 1);
               pc_in   = uc.target;
            end
         end
         COND_BIT_CLR: begin
            pc_in = exponent_ff[bit_ff] ? pc_ff + STEP_BITS'(1) : uc.target;
         end
         COND_MORE: begin
            if (bit_ff != '0) begin
               bit_in = bit_ff - EXP_IDX_BITS'(1);
               pc_in  = uc.target;
            end else begin
               pc_in = pc_ff + STEP_BITS'(1);
            end
         end
         COND_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = modulus_small ? '0 : acc_ff;
               pc_in        = uc.target;
            end
         end
         default: begin
            if (uc.mul) begin
               if (!issued_ff) begin
                  mul_start = 1'b1;
                  issued_in = 1'b1;
               end else if (mul_done) begin
                  issued_in = 1'b0;
                  pc_in     = uc.target;
                  if (uc.dst == DST_ACC) begin
                     acc_in = mul_p;
                  end else begin
                     base_in = mul_p;
                  end
               end
            end else begin
               pc_in = uc.target;
            end
         end
      endcase
   end

   bme_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .opa     (mul_a),
      .opb     (mul_b),
      .modulus (modulus_ff),
      .done    (mul_done),
      .product (mul_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff  <= EXPONENT_RESET;
         modulus_ff   <= MODULUS_RESET;
         pc_ff        <= S_WAIT;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         exponent_ff  <= exponent_in;
         modulus_ff   <= modulus_in;
         pc_ff        <= pc_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bit_ff      <= bit_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'(rsp_data_ff);

   // A multiply finishes only for a step that issued one.
   assert property (@(posedge clock) disable iff (reset) mul_done |-> issued_ff)
      else $error("multiplier finished with no multiply outstanding");

   // An accepted byte always starts with the base reduction.
   assert property (@(posedge clock) disable iff (reset) req_xfer |=> pc_ff == S_REDUCE)
      else $error("accepted byte did not start the program");

   // A residue is never dropped: the program waits while the output is held.
   assert property (@(posedge clock) disable iff (reset)
      (pc_ff == S_EMIT) && rsp_valid_ff && !rsp_tready |=> (pc_ff == S_EMIT) && rsp_valid_ff)
      else $error("result overwritten while the output was stalled");

endmodule
